/* design/asfc_pkg.sv */
// shared types and constants for the angle sensor frame checker
// no dependencies; used by every module in design/
`default_nettype none

package asfc_pkg;

    localparam int unsigned CMD_W     = 3;
    localparam int unsigned WORD_W    = 16;
    localparam int unsigned ANGLE_W   = 15;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned LINK_W    = 16;
    localparam int unsigned CRCCNT_W  = 16;
    localparam int unsigned RUN_W     = 8;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_W     = 16;

    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h1D;
    localparam logic [BYTE_W-1:0] CRC_SEED = 8'hFF;

    localparam logic [WORD_W-1:0] READ_COMMAND_RESET    = 16'h8021;
    localparam logic [RUN_W-1:0]  FAULT_THRESHOLD_RESET = 8'd5;

    localparam int unsigned RESET_OK_BIT  = 15;
    localparam int unsigned IF_OK_BIT     = 13;
    localparam int unsigned ANGLE_OK_BIT  = 12;

    typedef enum logic [CMD_W-1:0] {
        CMD_FRAME   = 3'd0,
        CMD_TIMEOUT = 3'd1,
        CMD_XFER    = 3'd2,
        CMD_CLEAR   = 3'd3,
        CMD_MISSING = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_TIMEOUT = 2'd1,
        EV_CRC     = 2'd2,
        EV_DATA    = 2'd3
    } fault_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_READ_COMMAND    = 1'b0,
        REG_FAULT_THRESHOLD = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [WORD_W-1:0] data_word;
        logic [WORD_W-1:0] check_word;
    } in_item_t;

    typedef struct packed {
        logic [ANGLE_W-1:0]  angle_raw;
        logic [BYTE_W-1:0]   status_byte;
        logic                reset_lost;
        logic                data_ok;
        logic                angle_usable;
        logic                crc_mismatch;
        logic [BYTE_W-1:0]   rx_crc_byte;
        logic [BYTE_W-1:0]   computed_crc;
        logic [1:0]          fault_event;
        logic [LINK_W-1:0]   link_error_count;
        logic [CRCCNT_W-1:0] crc_fail_total;
        logic [RUN_W-1:0]    error_run_count;
    } out_item_t;

    typedef struct packed {
        logic clear;
        logic link_inc;
        logic crc_inc;
        logic run_inc;
        logic run_clr;
    } cnt_upd_t;

    typedef struct packed {
        logic [LINK_W-1:0]   link;
        logic [CRCCNT_W-1:0] crc;
        logic [RUN_W-1:0]    run;
    } cnt_t;

endpackage

`default_nettype wire

/* design/asfc_crc.sv */
// crc-8 (poly 0x1d, seed 0xff, inverted) over command and data words, msb first
// depends on asfc_pkg
`default_nettype none

module asfc_crc
(
    input  wire logic [asfc_pkg::WORD_W-1:0] command,
    input  wire logic [asfc_pkg::WORD_W-1:0] data,
    output logic      [asfc_pkg::BYTE_W-1:0] crc
);

    function automatic logic [asfc_pkg::BYTE_W-1:0] crc_byte(
        input logic [asfc_pkg::BYTE_W-1:0] state,
        input logic [asfc_pkg::BYTE_W-1:0] byte_in
    );
        logic [asfc_pkg::BYTE_W-1:0] c;
        c = state ^ byte_in;
        for (int b = 0; b < asfc_pkg::BYTE_W; b++)
        begin
            if (c[asfc_pkg::BYTE_W-1])
                c = {c[asfc_pkg::BYTE_W-2:0], 1'b0} ^ asfc_pkg::CRC_POLY;
            else
                c = {c[asfc_pkg::BYTE_W-2:0], 1'b0};
        end
        return c;
    endfunction

    logic [asfc_pkg::BYTE_W-1:0] s0, s1, s2, s3;

    always_comb
    begin
        s0  = crc_byte(asfc_pkg::CRC_SEED, command[15:8]);
        s1  = crc_byte(s0, command[7:0]);
        s2  = crc_byte(s1, data[15:8]);
        s3  = crc_byte(s2, data[7:0]);
        crc = ~s3;
    end

endmodule

`default_nettype wire

/* design/asfc_counters.sv */
// saturating link-error, crc-error and error-run counters
// depends on asfc_pkg
`default_nettype none

module asfc_counters
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire asfc_pkg::cnt_upd_t upd,
    output asfc_pkg::cnt_t          cnt_next
);

    asfc_pkg::cnt_t cnt_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (upd.clear)
        begin
            cnt_next = '0;
        end
        else
        begin
            if (upd.link_inc && (cnt_reg.link != '1))
                cnt_next.link = cnt_reg.link + 1'b1;
            if (upd.crc_inc && (cnt_reg.crc != '1))
                cnt_next.crc = cnt_reg.crc + 1'b1;
            if (upd.run_clr)
                cnt_next.run = '0;
            else if (upd.run_inc && (cnt_reg.run != '1))
                cnt_next.run = cnt_reg.run + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (en)
            cnt_reg <= cnt_next;
    end

endmodule

`default_nettype wire

/* design/angle_sensor_frame_checker.sv */
// angle sensor frame checker: input register, one evaluation pass, result register
// one transaction per cycle while out_stall does not hold the result register
// counters and both channel valids clear on rst_n; read_command resets to 0x8021,
// fault_threshold to 5
// depends on asfc_pkg, asfc_crc, asfc_counters
`default_nettype none

module angle_sensor_frame_checker
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire asfc_pkg::in_item_t                   in_data,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output asfc_pkg::out_item_t                       out_data,
    input  wire logic                                 cfg_we,
    input  wire logic [asfc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [asfc_pkg::CFG_W-1:0]           cfg_data
);

    logic [asfc_pkg::WORD_W-1:0] read_command_reg;
    logic [asfc_pkg::RUN_W-1:0]  fault_threshold_reg;

    logic                in_valid_reg, in_valid_next;
    asfc_pkg::in_item_t  in_item_reg;
    logic                out_valid_reg, out_valid_next;
    asfc_pkg::out_item_t out_item_reg, out_item_next;

    logic adv, fire, take;

    logic [asfc_pkg::BYTE_W-1:0] calc_crc;
    asfc_pkg::cnt_upd_t          upd;
    asfc_pkg::cnt_t              cnt_next;

    logic [asfc_pkg::BYTE_W-1:0]  rx_crc;
    logic [asfc_pkg::ANGLE_W-1:0] angle;
    logic                         ok, bad;
    logic                         at_thr;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_command_reg    <= asfc_pkg::READ_COMMAND_RESET;
            fault_threshold_reg <= asfc_pkg::FAULT_THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (asfc_pkg::cfg_reg_t'(cfg_index))
                asfc_pkg::REG_READ_COMMAND:
                    read_command_reg <= cfg_data;
                asfc_pkg::REG_FAULT_THRESHOLD:
                    fault_threshold_reg <= cfg_data[asfc_pkg::RUN_W-1:0];
                default:
                    read_command_reg <= read_command_reg;
            endcase
        end
    end

    // handshake
    assign adv       = !out_valid_reg || !out_stall;
    assign fire      = in_valid_reg && adv;
    assign in_stall  = in_valid_reg && !adv;
    assign take      = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    always_comb
    begin
        if (take)
            in_valid_next = 1'b1;
        else if (adv)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (fire)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    asfc_crc u_crc
    (
        .command (read_command_reg),
        .data    (in_item_reg.data_word),
        .crc     (calc_crc)
    );

    asfc_counters u_counters
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (fire),
        .upd      (upd),
        .cnt_next (cnt_next)
    );

    // evaluation
    always_comb
    begin
        rx_crc = in_item_reg.check_word[asfc_pkg::BYTE_W-1:0];
        angle  = in_item_reg.data_word[asfc_pkg::ANGLE_W-1:0];
        ok     = in_item_reg.check_word[asfc_pkg::IF_OK_BIT] &&
                 in_item_reg.check_word[asfc_pkg::ANGLE_OK_BIT];
        bad    = rx_crc != calc_crc;
        upd    = '0;

        case (in_item_reg.cmd) inside
            asfc_pkg::CMD_FRAME:
            begin
                if (!ok || bad)
                begin
                    upd.crc_inc = bad;
                    if (ok && (angle != '0))
                        upd.run_clr = 1'b1;
                    else
                        upd.run_inc = 1'b1;
                end
                else
                begin
                    upd.run_clr = 1'b1;
                end
            end
            asfc_pkg::CMD_TIMEOUT, asfc_pkg::CMD_XFER:
            begin
                upd.link_inc = 1'b1;
                upd.run_inc  = 1'b1;
            end
            asfc_pkg::CMD_MISSING:
                upd.link_inc = 1'b1;
            asfc_pkg::CMD_CLEAR:
                upd.clear = 1'b1;
            default:
                upd = '0;
        endcase

        at_thr = cnt_next.run >= fault_threshold_reg;

        out_item_next                  = '0;
        out_item_next.link_error_count = cnt_next.link;
        out_item_next.crc_fail_total   = cnt_next.crc;
        out_item_next.error_run_count  = cnt_next.run;

        case (in_item_reg.cmd)
            asfc_pkg::CMD_FRAME:
            begin
                out_item_next.angle_raw    = angle;
                out_item_next.status_byte  = in_item_reg.check_word[15:8];
                out_item_next.reset_lost   =
                    !in_item_reg.check_word[asfc_pkg::RESET_OK_BIT];
                out_item_next.data_ok      = ok;
                out_item_next.rx_crc_byte  = rx_crc;
                out_item_next.computed_crc = calc_crc;
                if (!ok || bad)
                begin
                    out_item_next.crc_mismatch = bad;
                    out_item_next.angle_usable = ok && (angle != '0);
                    if (at_thr)
                        out_item_next.fault_event = ok ? asfc_pkg::EV_CRC
                                                       : asfc_pkg::EV_DATA;
                end
                else
                begin
                    out_item_next.angle_usable = 1'b1;
                end
            end
            asfc_pkg::CMD_TIMEOUT:
            begin
                out_item_next.crc_mismatch = 1'b1;
                if (at_thr)
                    out_item_next.fault_event = asfc_pkg::EV_TIMEOUT;
            end
            asfc_pkg::CMD_XFER:
            begin
                out_item_next.crc_mismatch = 1'b1;
                if (at_thr)
                    out_item_next.fault_event = asfc_pkg::EV_DATA;
            end
            asfc_pkg::CMD_MISSING:
                out_item_next.crc_mismatch = 1'b1;
            default:
                out_item_next.crc_mismatch = 1'b0;
        endcase
    end

    // pipeline registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            in_item_reg <= in_data;
        if (fire)
            out_item_reg <= out_item_next;
    end

endmodule

`default_nettype wire

/* test/asfc_result_checker.sv */
// result checker for the angle sensor frame checker: predicts each transaction, compares outputs
// depends on asfc_pkg; instantiated beside the block by tb_angle_sensor_frame_checker
module asfc_result_checker
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    input  wire logic                           in_stall,
    input  wire asfc_pkg::in_item_t             in_data,
    input  wire logic                           out_valid,
    input  wire logic                           out_stall,
    input  wire asfc_pkg::out_item_t            out_data,
    input  wire logic                           cfg_we,
    input  wire logic [asfc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [asfc_pkg::CFG_W-1:0]     cfg_data,
    output logic [31:0]                         failures,
    output logic [31:0]                         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [asfc_pkg::WORD_W-1:0]   command_word;
    logic [asfc_pkg::RUN_W-1:0]    threshold;
    logic [asfc_pkg::LINK_W-1:0]   link_total;
    logic [asfc_pkg::CRCCNT_W-1:0] crc_total;
    logic [asfc_pkg::RUN_W-1:0]    run_length;
    asfc_pkg::out_item_t           predicted_results[$];
    asfc_pkg::out_item_t           oldest;

    function automatic logic [asfc_pkg::BYTE_W-1:0] frame_crc8(
        input logic [asfc_pkg::WORD_W-1:0] cmd_w,
        input logic [asfc_pkg::WORD_W-1:0] data_w);
        logic [2*asfc_pkg::WORD_W-1:0] msg;
        logic [asfc_pkg::BYTE_W-1:0]   c;
        msg = {cmd_w, data_w};
        c = asfc_pkg::CRC_SEED;
        for (int i = 2*asfc_pkg::WORD_W-1; i >= 0; i--)
        begin
            if (c[asfc_pkg::BYTE_W-1] ^ msg[i])
                c = {c[asfc_pkg::BYTE_W-2:0], 1'b0} ^ asfc_pkg::CRC_POLY;
            else
                c = {c[asfc_pkg::BYTE_W-2:0], 1'b0};
        end
        return ~c;
    endfunction

    function automatic void bump_run();
        if (run_length != {asfc_pkg::RUN_W{1'b1}})
            run_length = run_length + 1'b1;
    endfunction

    function automatic void bump_link();
        if (link_total != {asfc_pkg::LINK_W{1'b1}})
            link_total = link_total + 1'b1;
    endfunction

    // advances the counters for one transaction and returns its expected result
    function automatic asfc_pkg::out_item_t evaluate_event(input asfc_pkg::in_item_t t);
        asfc_pkg::out_item_t r;
        logic                ok;
        logic                bad;
        r = '0;
        case (t.cmd) inside
            asfc_pkg::CMD_FRAME:
            begin
                r.angle_raw    = t.data_word[asfc_pkg::ANGLE_W-1:0];
                r.status_byte  = t.check_word[asfc_pkg::WORD_W-1:asfc_pkg::BYTE_W];
                r.reset_lost   = ~t.check_word[asfc_pkg::RESET_OK_BIT];
                ok             = t.check_word[asfc_pkg::IF_OK_BIT] &
                                 t.check_word[asfc_pkg::ANGLE_OK_BIT];
                r.data_ok      = ok;
                r.rx_crc_byte  = t.check_word[asfc_pkg::BYTE_W-1:0];
                r.computed_crc = frame_crc8(command_word, t.data_word);
                bad            = r.rx_crc_byte != r.computed_crc;
                if (!ok || bad)
                begin
                    r.crc_mismatch = bad;
                    if (bad && crc_total != {asfc_pkg::CRCCNT_W{1'b1}})
                        crc_total = crc_total + 1'b1;
                    if (ok && r.angle_raw != '0)
                    begin
                        r.angle_usable = 1'b1;
                        run_length     = '0;
                    end
                    else
                        bump_run();
                    if (run_length >= threshold)
                        r.fault_event = ok ? asfc_pkg::EV_CRC : asfc_pkg::EV_DATA;
                end
                else
                begin
                    r.angle_usable = 1'b1;
                    run_length     = '0;
                end
            end
            asfc_pkg::CMD_TIMEOUT, asfc_pkg::CMD_XFER:
            begin
                r.crc_mismatch = 1'b1;
                bump_link();
                bump_run();
                if (run_length >= threshold)
                    r.fault_event = (t.cmd == asfc_pkg::CMD_TIMEOUT) ? asfc_pkg::EV_TIMEOUT
                                                                     : asfc_pkg::EV_DATA;
            end
            asfc_pkg::CMD_MISSING:
            begin
                r.crc_mismatch = 1'b1;
                bump_link();
            end
            asfc_pkg::CMD_CLEAR:
            begin
                link_total = '0;
                crc_total  = '0;
                run_length = '0;
            end
            default:
            begin
            end
        endcase
        r.link_error_count = link_total;
        r.crc_fail_total   = crc_total;
        r.error_run_count  = run_length;
        return r;
    endfunction

    function automatic string show(input asfc_pkg::out_item_t r);
        return $sformatf({"angle %h status %h rst %b ok %b valid %b mism %b rx %h calc %h ",
                          "event %0d link %0d crc %0d run %0d"},
                         r.angle_raw, r.status_byte, r.reset_lost, r.data_ok, r.angle_usable,
                         r.crc_mismatch, r.rx_crc_byte, r.computed_crc, r.fault_event,
                         r.link_error_count, r.crc_fail_total, r.error_run_count);
    endfunction

    task automatic note_failure(input string what);
        failures = failures + 1;
        if (failures <= 10)
            $display("%0t: %s", $realtime, what);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            command_word = asfc_pkg::READ_COMMAND_RESET;
            threshold    = asfc_pkg::FAULT_THRESHOLD_RESET;
            link_total   = '0;
            crc_total    = '0;
            run_length   = '0;
            predicted_results.delete();
            pending      = 0;
            failures     = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (predicted_results.size() == 0)
                    note_failure({"unexpected transaction: ", show(out_data)});
                else
                begin
                    oldest = predicted_results.pop_front();
                    if (out_data !== oldest)
                        note_failure({"mismatch\n  expected ", show(oldest),
                                      "\n  actual   ", show(out_data)});
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    asfc_pkg::REG_READ_COMMAND:    command_word = cfg_data;
                    asfc_pkg::REG_FAULT_THRESHOLD: threshold = cfg_data[asfc_pkg::RUN_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (in_valid && !in_stall)
                predicted_results.push_back(evaluate_event(in_data));
            pending = predicted_results.size();
        end
    end

endmodule

/* test/tb_angle_sensor_frame_checker.sv */
// testbench top for angle_sensor_frame_checker: clock, reset, stimulus, idling and verdict
// depends on asfc_pkg, the block under test and asfc_result_checker
module tb_angle_sensor_frame_checker;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_PER_PHASE = 190;
    localparam int PHASES           = 5;
    localparam int LIMIT_NS         = 2_000_000;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    asfc_pkg::in_item_t             in_data = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    asfc_pkg::out_item_t            out_data;
    logic                           cfg_we = 1'b0;
    logic [asfc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [asfc_pkg::CFG_W-1:0]     cfg_data = '0;
    logic [31:0]                    failures;
    logic [31:0]                    pending;

    logic                           calm = 1'b0;
    logic [asfc_pkg::WORD_W-1:0]    active_command = asfc_pkg::READ_COMMAND_RESET;

    always #1 clk = ~clk;

    angle_sensor_frame_checker dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    asfc_result_checker u_result_check
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .failures  (failures),
        .pending   (pending)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // crc the sensor appends, used to build frames with a good or a deliberately broken crc byte
    function automatic logic [asfc_pkg::BYTE_W-1:0] sensor_crc(
        input logic [asfc_pkg::WORD_W-1:0] cmd_w,
        input logic [asfc_pkg::WORD_W-1:0] data_w);
        logic [2*asfc_pkg::WORD_W-1:0] msg;
        logic [asfc_pkg::BYTE_W-1:0]   c;
        msg = {cmd_w, data_w};
        c = asfc_pkg::CRC_SEED;
        for (int i = 2*asfc_pkg::WORD_W-1; i >= 0; i--)
        begin
            if (c[asfc_pkg::BYTE_W-1] ^ msg[i])
                c = {c[asfc_pkg::BYTE_W-2:0], 1'b0} ^ asfc_pkg::CRC_POLY;
            else
                c = {c[asfc_pkg::BYTE_W-2:0], 1'b0};
        end
        return ~c;
    endfunction

    function automatic asfc_pkg::in_item_t frame_item(input logic [asfc_pkg::WORD_W-1:0] d,
                                                      input logic [asfc_pkg::BYTE_W-1:0] st,
                                                      input logic crc_good);
        asfc_pkg::in_item_t t;
        t.cmd        = asfc_pkg::CMD_FRAME;
        t.data_word  = d;
        t.check_word = {st, sensor_crc(active_command, d) ^ (crc_good ? 8'h00 : 8'h01)};
        return t;
    endfunction

    function automatic asfc_pkg::in_item_t event_item(input logic [asfc_pkg::CMD_W-1:0] c);
        asfc_pkg::in_item_t t;
        t.cmd        = c;
        t.data_word  = 16'($urandom);
        t.check_word = 16'($urandom);
        return t;
    endfunction

    function automatic asfc_pkg::in_item_t random_item();
        asfc_pkg::in_item_t t;
        int                 r;
        r = $urandom_range(0, 99);
        if (r < 55)
            t = frame_item(16'($urandom), $urandom_range(0, 3) != 0 ? 8'($urandom) | 8'h30
                                                                     : 8'($urandom), 1'b1);
        else if (r < 65)
        begin
            t = frame_item(16'($urandom),
                           8'($urandom) | ($urandom_range(0, 1) ? 8'h30 : 8'h00), 1'b1);
            t.check_word[asfc_pkg::BYTE_W-1:0] = 8'($urandom);
        end
        else if (r < 75)
            t = event_item(asfc_pkg::CMD_TIMEOUT);
        else if (r < 82)
            t = event_item(asfc_pkg::CMD_XFER);
        else if (r < 88)
            t = event_item(asfc_pkg::CMD_MISSING);
        else if (r < 91)
            t = event_item(asfc_pkg::CMD_CLEAR);
        else if (r < 96)
            t = event_item(3'($urandom_range(5, 7)));
        else
            t = frame_item(16'($urandom) & 16'h8000, 8'($urandom) | 8'h30, 1'b0);
        return t;
    endfunction

    task automatic send(input asfc_pkg::in_item_t t);
        int gap;
        in_valid <= 1'b1;
        in_data  <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_config(input logic [asfc_pkg::WORD_W-1:0] c,
                              input logic [asfc_pkg::RUN_W-1:0] th);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= asfc_pkg::REG_READ_COMMAND;
        cfg_data  <= c;
        @(negedge clk);
        cfg_index <= asfc_pkg::REG_FAULT_THRESHOLD;
        cfg_data  <= asfc_pkg::CFG_W'(th);
        @(negedge clk);
        cfg_we <= 1'b0;
        active_command = c;
        @(negedge clk);
    endtask

    // receiver side: stall bursts of random length, none while calm
    initial
    begin
        int hold;
        int r;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
                hold--;
            else
            begin
                r = $urandom_range(0, 99);
                if (calm || r < 65)
                begin
                    out_stall <= 1'b0;
                    hold = $urandom_range(0, 8);
                end
                else
                begin
                    out_stall <= 1'b1;
                    hold = (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 40);
                end
            end
        end
    end

    initial
    begin
        #(LIMIT_NS);
        $display("angle_sensor_frame_checker verification failed");
        $finish;
    end

    initial
    begin
        logic [asfc_pkg::WORD_W-1:0] c;
        logic [asfc_pkg::RUN_W-1:0]  th;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part at reset settings
        send(frame_item(16'hFFFF, 8'hFF, 1'b1));
        send(frame_item(16'h0000, 8'h30, 1'b1));
        send(frame_item(16'h7FFF, 8'h00, 1'b1));
        send(frame_item(16'h1234, 8'hB0, 1'b0));
        send(frame_item(16'h8000, 8'h30, 1'b0));
        send(frame_item(16'h0001, 8'h20, 1'b0));
        send(frame_item(16'h4AC3, 8'h90, 1'b1));
        repeat (4) send(event_item(asfc_pkg::CMD_TIMEOUT));
        send(event_item(asfc_pkg::CMD_XFER));
        send(event_item(asfc_pkg::CMD_MISSING));
        send(event_item(asfc_pkg::CMD_XFER));
        send(event_item(asfc_pkg::CMD_TIMEOUT));
        send(event_item(asfc_pkg::CMD_CLEAR));
        send('{cmd: 3'd5, data_word: 16'hFFFF, check_word: 16'hFFFF});
        send('{cmd: 3'd6, data_word: 16'h0000, check_word: 16'h0000});
        send('{cmd: 3'd7, data_word: 16'hFFFF, check_word: 16'hFFFF});
        send(event_item(asfc_pkg::CMD_MISSING));
        send('{cmd: asfc_pkg::CMD_FRAME, data_word: 16'h0000, check_word: 16'hFFFF});
        send(frame_item(16'h2222, 8'hF0, 1'b1));

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       begin c = 16'h0000;        th = 8'd1;   end
                1:       begin c = 16'hFFFF;        th = 8'd255; end
                2:       begin c = 16'($urandom);   th = 8'($urandom_range(2, 12)); end
                3:       begin c = 16'h8021;        th = 8'd0;   end
                default: begin c = 16'($urandom);   th = 8'd5;   end
            endcase
            set_config(c, th);
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                calm = (n < 30);
                send(random_item());
            end
            calm = 1'b0;
            if (th == 8'd255)
            begin
                // long error run: reach the threshold and saturate the run counter
                repeat (260) send(event_item(asfc_pkg::CMD_TIMEOUT));
                send(frame_item(16'($urandom), 8'hFF, 1'b1));
            end
        end

        drain();
        repeat (10) @(negedge clk);
        if (failures == 0 && pending == 0)
            $display("angle_sensor_frame_checker verification clean");
        else
            $display("angle_sensor_frame_checker verification failed");
        $finish;
    end

endmodule

/* files.f */
design/asfc_pkg.sv
design/asfc_crc.sv
design/asfc_counters.sv
design/angle_sensor_frame_checker.sv
test/asfc_result_checker.sv
test/tb_angle_sensor_frame_checker.sv
